@@ hw/rtl/tadc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants, calibration table and divider step for the thermistor converter.
package tadc_pkg;

	localparam int ROM_SIZE = 34;
	localparam int ADC_W    = 10;
	localparam int TEMP_W   = 10;
	localparam int ROM_T_W  = 9;
	localparam int RES_W    = 19;
	localparam int IDX_W    = $clog2(ROM_SIZE);
	localparam int CNT_W    = $clog2(ROM_SIZE + 1);

	// divider: dividend bits shifted through the partial remainder
	localparam int DIV_BITS            = ROM_T_W + ADC_W;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES          = (DIV_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

	localparam int RES_NUM_W = 24;

	localparam logic [ADC_W-1:0]     COLD_LIMIT    = 10'd30;
	localparam logic [ADC_W-1:0]     HOT_LIMIT     = 10'd1010;
	localparam logic [RES_NUM_W-1:0] RES_NUMERATOR = 24'd10240000;
	localparam logic [DIV_BITS-1:0]  RES_OFFSET    = 19'd10000;
	// upper numerator bits start as the remainder; below any valid divisor (>= 30)
	localparam logic [ADC_W-1:0]     RES_REM_INIT  =
		ADC_W'(RES_NUMERATOR[RES_NUM_W-1:DIV_BITS]);

	localparam logic [ADC_W-1:0] ROM_ADC [ROM_SIZE] = '{
		10'd30,   10'd76,   10'd93,   10'd113,  10'd223,  10'd414,  10'd613,
		10'd827,  10'd853,  10'd870,  10'd884,  10'd897,  10'd909,  10'd921,
		10'd931,  10'd940,  10'd948,  10'd955,  10'd962,  10'd968,  10'd972,
		10'd977,  10'd981,  10'd985,  10'd988,  10'd991,  10'd994,  10'd997,
		10'd1001, 10'd1003, 10'd1004, 10'd1006, 10'd1007, 10'd1010
	};

	localparam logic [ROM_T_W-1:0] ROM_TEMP [ROM_SIZE] = '{
		9'd0,   9'd20,  9'd25,  9'd30,  9'd50,  9'd75,  9'd100,
		9'd140, 9'd145, 9'd150, 9'd155, 9'd160, 9'd165, 9'd170,
		9'd175, 9'd180, 9'd185, 9'd190, 9'd195, 9'd200, 9'd205,
		9'd210, 9'd215, 9'd220, 9'd225, 9'd230, 9'd235, 9'd240,
		9'd250, 9'd255, 9'd260, 9'd265, 9'd270, 9'd280
	};

	typedef enum logic [1:0] {
		KIND_EXACT  = 2'd0,
		KIND_INTERP = 2'd1,
		KIND_COLD   = 2'd2,
		KIND_HOT    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ADC_W-1:0] x;
		logic [CNT_W-1:0] cnt;        // number of used entries <= x
		logic             exact;
		logic             no_bracket;
	} loc_t;

	typedef struct packed {
		logic [ADC_W-1:0]    rem;
		logic [DIV_BITS-1:0] qd;      // dividend bits in, quotient bits out
		logic [ADC_W-1:0]    d;
	} div_lane_t;

	typedef struct packed {
		kind_t              kind;
		logic [ROM_T_W-1:0] base_t;
		logic               use_div;
	} side_t;

	typedef struct packed {
		div_lane_t interp;
		div_lane_t res;
		side_t     side;
	} divw_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_c;
		logic [RES_W-1:0]         resistance_ohms;
		kind_t                    result_kind;
	} result_t;

	function automatic logic [ADC_W-1:0] rom_adc(input logic [CNT_W-1:0] idx);
		logic [ADC_W-1:0] v;
		v = '0;
		if (idx < CNT_W'(ROM_SIZE)) v = ROM_ADC[idx[IDX_W-1:0]];
		return v;
	endfunction

	function automatic logic [ROM_T_W-1:0] rom_temp(input logic [CNT_W-1:0] idx);
		logic [ROM_T_W-1:0] v;
		v = '0;
		if (idx < CNT_W'(ROM_SIZE)) v = ROM_TEMP[idx[IDX_W-1:0]];
		return v;
	endfunction

	// one restoring division step
	function automatic div_lane_t div_step(input div_lane_t l);
		logic [ADC_W:0] t;
		div_lane_t      r;
		r = l;
		t = {l.rem, l.qd[DIV_BITS-1]};
		if (t >= {1'b0, l.d}) begin
			r.rem = ADC_W'(t - {1'b0, l.d});
			r.qd  = {l.qd[DIV_BITS-2:0], 1'b1};
		end else begin
			r.rem = t[ADC_W-1:0];
			r.qd  = {l.qd[DIV_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/tadc_sample_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one converter sample.
interface tadc_sample_if import tadc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_value;

	modport source (output valid, output adc_value, input ready);
	modport sink   (input valid, input adc_value, output ready);
endinterface

@@ hw/rtl/tadc_result_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one temperature result.
interface tadc_result_if import tadc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_c;
	logic [RES_W-1:0]         resistance_ohms;
	logic [1:0]               result_kind;

	modport source (output valid, output temperature_c, output resistance_ohms,
		output result_kind, input ready);
	modport sink   (input valid, input temperature_c, input resistance_ohms,
		input result_kind, output ready);
endinterface

@@ hw/rtl/tadc_locate.sv @@
`timescale 1ns / 1ps
// Stage 1: compares the sample against every used table entry and registers its position.
module tadc_locate import tadc_pkg::*; #(
	parameter int USED = ROM_SIZE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ADC_W-1:0] adc_value,
	output logic             out_valid,
	input  logic             out_ready,
	output loc_t             out_data
);

	logic [ROM_SIZE-1:0] le;
	logic [ROM_SIZE-1:0] eq;
	logic [ROM_SIZE:0]   le_ext;
	logic [CNT_W-1:0]    cnt;
	logic                valid_s1;
	loc_t                data_s1;

	always_comb begin
		le = '0;
		eq = '0;
		for (int i = 0; i < ROM_SIZE; i++) begin
			if (i < USED) begin
				le[i] = (ROM_ADC[i] <= adc_value);
				eq[i] = (ROM_ADC[i] == adc_value);
			end
		end
	end

	assign le_ext = {1'b0, le};

	// table is sorted, so le is a thermometer code; pick its top edge
	always_comb begin
		cnt = '0;
		for (int i = 0; i < ROM_SIZE; i++) begin
			if (le_ext[i] && !le_ext[i+1]) cnt = cnt | CNT_W'(i + 1);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.x          <= adc_value;
			data_s1.cnt        <= cnt;
			data_s1.exact      <= |eq;
			data_s1.no_bracket <= (cnt == '0) || (cnt >= CNT_W'(USED));
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ hw/rtl/tadc_setup.sv @@
`timescale 1ns / 1ps
// Stage 2: reads the bracket entries, classifies the sample and forms the divider operands.
module tadc_setup import tadc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  loc_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output divw_t out_data
);

	logic [CNT_W-1:0]    lo_idx;
	logic [ADC_W-1:0]    small_a;
	logic [ADC_W-1:0]    big_a;
	logic [ROM_T_W-1:0]  small_t;
	logic [ROM_T_W-1:0]  big_t;
	logic [ROM_T_W-1:0]  dt;
	logic [ADC_W-1:0]    dx;
	logic [DIV_BITS-1:0] prod;
	side_t               side;
	divw_t               nxt;
	logic                valid_s2;
	divw_t               data_s2;

	assign lo_idx  = (in_data.cnt == '0) ? '0 : in_data.cnt - CNT_W'(1);
	assign small_a = rom_adc(lo_idx);
	assign big_a   = rom_adc(in_data.cnt);
	assign small_t = rom_temp(lo_idx);
	assign big_t   = rom_temp(in_data.cnt);
	assign dt      = big_t - small_t;
	assign dx      = in_data.x - small_a;
	assign prod    = DIV_BITS'(dt) * DIV_BITS'(dx);

	always_comb begin
		side.kind    = KIND_HOT;
		side.base_t  = '0;
		side.use_div = 1'b0;
		priority if (in_data.exact) begin
			side.kind   = KIND_EXACT;
			side.base_t = small_t;
		end else if (in_data.x < COLD_LIMIT) begin
			side.kind = KIND_COLD;
		end else if (in_data.x > HOT_LIMIT) begin
			side.kind = KIND_HOT;
		end else if (in_data.no_bracket) begin
			side.kind = KIND_HOT;
		end else begin
			side.kind    = KIND_INTERP;
			side.base_t  = small_t;
			side.use_div = !(big_a <= small_a || in_data.x < small_a || big_t < small_t);
		end
	end

	always_comb begin
		nxt.interp.rem = '0;
		nxt.interp.qd  = prod;
		nxt.interp.d   = big_a - small_a;
		nxt.res.rem    = RES_REM_INIT;
		nxt.res.qd     = RES_NUMERATOR[DIV_BITS-1:0];
		nxt.res.d      = in_data.x;
		nxt.side       = side;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

@@ hw/rtl/tadc_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two lanes in lockstep: interpolation quotient and resistance.
module tadc_div_pipe import tadc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  divw_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output divw_t out_data
);

	// arrays indexed by divider stage
	logic  valid_sk [DIV_STAGES];
	divw_t data_sk  [DIV_STAGES];
	logic  ready_k  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
		divw_t src;
		divw_t nxt;
		logic  src_valid;
		logic  dst_ready;

		if (k == 0) begin : g_first
			assign src       = in_data;
			assign src_valid = in_valid;
		end else begin : g_mid
			assign src       = data_sk[k-1];
			assign src_valid = valid_sk[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_last
			assign dst_ready = out_ready;
		end else begin : g_inner
			assign dst_ready = ready_k[k+1];
		end

		assign ready_k[k] = !valid_sk[k] || dst_ready;

		always_comb begin
			nxt = src;
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				if (k * DIV_STEPS_PER_STAGE + j < DIV_BITS) begin
					nxt.interp = div_step(nxt.interp);
					nxt.res    = div_step(nxt.res);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k] <= 1'b0;
			end else if (ready_k[k]) begin
				valid_sk[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (ready_k[k] && src_valid) begin
				data_sk[k] <= nxt;
			end
		end
	end

	assign in_ready  = ready_k[0];
	assign out_valid = valid_sk[DIV_STAGES-1];
	assign out_data  = data_sk[DIV_STAGES-1];

endmodule

@@ hw/rtl/tadc_finish.sv @@
`timescale 1ns / 1ps
// Output stage: assembles temperature, resistance and kind into the result register.
module tadc_finish import tadc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  divw_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic [DIV_BITS-1:0] q_r;
	result_t             nxt;
	logic                valid_s8;
	result_t             data_s8;

	assign q_r = in_data.res.qd;

	always_comb begin
		nxt.result_kind     = in_data.side.kind;
		nxt.temperature_c   = '0;
		nxt.resistance_ohms = '0;
		unique case (in_data.side.kind)
			KIND_EXACT: begin
				nxt.temperature_c = TEMP_W'(in_data.side.base_t);
			end
			KIND_INTERP: begin
				nxt.temperature_c = TEMP_W'(in_data.side.base_t)
					+ (in_data.side.use_div ? TEMP_W'(in_data.interp.qd) : '0);
				nxt.resistance_ohms = (q_r >= RES_OFFSET) ? RES_W'(q_r - RES_OFFSET) : '0;
			end
			KIND_COLD: begin
				nxt.temperature_c = '0;
			end
			KIND_HOT: begin
				nxt.temperature_c = '1;
			end
		endcase
	end

	assign in_ready = !valid_s8 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (in_ready) begin
			valid_s8 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s8 <= nxt;
		end
	end

	assign out_valid = valid_s8;
	assign out_data  = data_s8;

endmodule

@@ hw/rtl/thermistor_adc_to_temperature_top.sv @@
`timescale 1ns / 1ps
// Top level of the thermistor sample to temperature converter.
//
// Converts each 10-bit converter sample into a temperature in whole degrees C using a
// fixed 34-point calibration table. A sample that equals a table point returns that
// point's temperature (kind 0); below 30 it is reported too cold (kind 2, temperature 0);
// above 1010, or outside the used part of the table, too hot (kind 3, temperature -1).
// Anything else is linearly interpolated between its two bracketing points, truncated,
// and also gets the divider resistance floor(10240000/adc) - 10000 (kind 1); resistance
// is 0 on every other kind. The block is fully pipelined: one sample per cycle on both
// channels while results are taken. Its stages are the table compare stage, the
// operand setup stage (bracket lookup and the interpolation multiply), five divider
// stages that run the 19-step restoring division four steps each (three in the last),
// and the output register. Each stage has its own valid bit and ready, so a stalled
// result only holds the stages that are full; empty slots behind it keep taking
// samples. TABLE_ENTRIES limits how many leading table points take part (values above
// 34 use the whole table). No state is kept between samples and there are no
// configuration registers.
module thermistor_adc_to_temperature_top import tadc_pkg::*; #(
	parameter int TABLE_ENTRIES = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	tadc_sample_if.sink   sample,
	tadc_result_if.source result
);

	localparam int USED = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;

	// stage-to-stage transfers
	logic    loc_valid;
	logic    loc_ready;
	loc_t    loc_data;
	logic    set_valid;
	logic    set_ready;
	divw_t   set_data;
	logic    div_valid;
	logic    div_ready;
	divw_t   div_data;
	result_t res_data;

	// compare sample against the table
	tadc_locate #(
		.USED(USED)
	) u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.adc_value (sample.adc_value),
		.out_valid (loc_valid),
		.out_ready (loc_ready),
		.out_data  (loc_data)
	);

	// bracket lookup, classification, interpolation product
	tadc_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (loc_valid),
		.in_ready  (loc_ready),
		.in_data   (loc_data),
		.out_valid (set_valid),
		.out_ready (set_ready),
		.out_data  (set_data)
	);

	// both divisions in lockstep
	tadc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (set_valid),
		.in_ready  (set_ready),
		.in_data   (set_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	// final select and output register
	tadc_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.temperature_c   = res_data.temperature_c;
	assign result.resistance_ohms = res_data.resistance_ohms;
	assign result.result_kind     = res_data.result_kind;

endmodule

@@ hw/rtl/tadc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the converter top level, bound to it below.
module tadc_checker import tadc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [TEMP_W-1:0] temperature_c,
	input logic [RES_W-1:0]         resistance_ohms,
	input logic [1:0]               result_kind
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped without a transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({temperature_c, resistance_ohms, result_kind}))
		else $error("stalled result changed");

	a_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_INTERP) |-> resistance_ohms == '0)
		else $error("resistance nonzero on a non-interpolated result");

	a_limits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_HOT || result_kind == KIND_COLD)
		|-> ((result_kind == KIND_HOT) ? (temperature_c == '1) : (temperature_c == '0)))
		else $error("limit result with wrong temperature");

endmodule

bind thermistor_adc_to_temperature_top tadc_checker u_tadc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.temperature_c   (result.temperature_c),
	.resistance_ohms (result.resistance_ohms),
	.result_kind     (result.result_kind)
);
